### rtl/core/golden_ratio_hsv_color_generator_macros.svh
// ----------------------------------------------------------------------------
// Golden-ratio HSV colour generator: assertion macros
// Concurrent assertion shorthands used by grhsv_checker.
// ----------------------------------------------------------------------------
`ifndef GOLDEN_RATIO_HSV_COLOR_GENERATOR_MACROS_SVH
`define GOLDEN_RATIO_HSV_COLOR_GENERATOR_MACROS_SVH

// Same-cycle implication, disabled while rst is high.
`define GRHSV_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while rst is high.
`define GRHSV_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/grhsv_pkg.sv
// ----------------------------------------------------------------------------
// grhsv_pkg
// Shared constants and controller/datapath command types.
// ----------------------------------------------------------------------------
`default_nettype none

package grhsv_pkg;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_HUE_SEED = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HUE_STEP = 2'd1;

   // golden-ratio conjugate as a 16-bit fraction of one turn
   localparam logic [CSR_DATA_BITS-1:0] HUE_STEP_RESET = 16'd40503;

   typedef enum logic [2:0] {
      OP_IDLE,
      OP_ACCEPT,
      OP_HUE,
      OP_MUL_SF,
      OP_MUL,
      OP_ROUND,
      OP_DIV,
      OP_FIX
   } op_type;

   typedef enum logic [1:0] {
      CHAN_P,
      CHAN_Q,
      CHAN_T
   } chan_type;

   typedef struct packed {
      op_type   op;
      chan_type chan;
      logic     load_out;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

### rtl/core/grhsv_if.sv
// ----------------------------------------------------------------------------
// grhsv request and response channels
// Valid/ready channels carrying one request and one colour result.
// ----------------------------------------------------------------------------
`default_nettype none

interface grhsv_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] saturation;
   logic [7:0] value_level;
   logic [7:0] alpha_level;

   modport source (output valid, output saturation, output value_level,
                   output alpha_level, input ready);
   modport sink   (input valid, input saturation, input value_level,
                   input alpha_level, output ready);
endinterface

interface grhsv_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] color_abgr;
   logic [15:0] hue_used;

   modport source (output valid, output color_abgr, output hue_used, input ready);
   modport sink   (input valid, input color_abgr, input hue_used, output ready);
endinterface

`default_nettype wire

### rtl/core/grhsv_ctrl.sv
// ----------------------------------------------------------------------------
// grhsv_ctrl
// Sequencer: steps one request through hue update, products, rounding and division.
// ----------------------------------------------------------------------------
`default_nettype none

module grhsv_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire grhsv_pkg::status_type status,
   output grhsv_pkg::cmd_type        cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HUE,
      ST_SF,
      ST_MUL,
      ST_RND,
      ST_DIV,
      ST_FIX,
      ST_LOAD
   } state_type;

   state_type           state_ff, state_in;
   grhsv_pkg::chan_type chan_ff, chan_in;
   grhsv_pkg::chan_type chan_next;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      unique case (chan_ff)
         grhsv_pkg::CHAN_P: chan_next = grhsv_pkg::CHAN_Q;
         grhsv_pkg::CHAN_Q: chan_next = grhsv_pkg::CHAN_T;
         default:           chan_next = grhsv_pkg::CHAN_P;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      chan_in      = chan_ff;
      cmd.op       = grhsv_pkg::OP_IDLE;
      cmd.chan     = chan_ff;
      cmd.load_out = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = grhsv_pkg::OP_ACCEPT;
               state_in = ST_HUE;
            end
         end
         ST_HUE: begin
            cmd.op   = grhsv_pkg::OP_HUE;
            state_in = ST_SF;
         end
         ST_SF: begin
            cmd.op   = grhsv_pkg::OP_MUL_SF;
            chan_in  = grhsv_pkg::CHAN_P;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.op   = grhsv_pkg::OP_MUL;
            state_in = ST_RND;
         end
         ST_RND: begin
            cmd.op   = grhsv_pkg::OP_ROUND;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.op   = grhsv_pkg::OP_DIV;
            state_in = ST_FIX;
         end
         ST_FIX: begin
            cmd.op = grhsv_pkg::OP_FIX;
            if (chan_ff == grhsv_pkg::CHAN_T) begin
               state_in = ST_LOAD;
            end else begin
               chan_in  = chan_next;
               state_in = ST_MUL;
            end
         end
         ST_LOAD: begin
            // hold until the output register can take the colour
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         chan_ff  <= grhsv_pkg::CHAN_P;
      end else begin
         state_ff <= state_in;
         chan_ff  <= chan_in;
      end
   end

endmodule

`default_nettype wire

### rtl/core/grhsv_datapath.sv
// ----------------------------------------------------------------------------
// grhsv_datapath
// Hue accumulator, shared multiplier, divide-by-255 rounding, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module grhsv_datapath #(
   parameter int HUE_BITS = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire grhsv_pkg::cmd_type                     cmd,
   output grhsv_pkg::status_type                       status,
   input  wire logic                                   csr_we,
   input  wire logic [grhsv_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [grhsv_pkg::CSR_DATA_BITS-1:0]    csr_wdata,
   input  wire logic [7:0]                             req_saturation,
   input  wire logic [7:0]                             req_value_level,
   input  wire logic [7:0]                             req_alpha_level,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output logic [31:0]                                 rsp_color_abgr,
   output logic [15:0]                                 rsp_hue_used
);

   localparam int B          = HUE_BITS;
   localparam int UP_SHIFT   = (B >= 16) ? B - 16 : 0;
   localparam int DOWN_SHIFT = (B < 16) ? 16 - B : 0;

   localparam logic [B+7:0]  FULL_SCALE = {8'd255, {B{1'b0}}};
   localparam logic [B+16:0] ROUND_BIAS = (B+17)'(255) << (B - 1);

   localparam logic [2:0] SEC_RED_YELLOW    = 3'd0;
   localparam logic [2:0] SEC_YELLOW_GREEN  = 3'd1;
   localparam logic [2:0] SEC_GREEN_CYAN    = 3'd2;
   localparam logic [2:0] SEC_CYAN_BLUE     = 3'd3;
   localparam logic [2:0] SEC_BLUE_MAGENTA  = 3'd4;

   function automatic logic [B-1:0] to_hue(input logic [15:0] x);
      logic [B+15:0] w;
      w = (B+16)'(x);
      w = (w << UP_SHIFT) >> DOWN_SHIFT;
      return w[B-1:0];
   endfunction

   function automatic logic [15:0] to_16(input logic [B-1:0] h);
      logic [B+15:0] w;
      w = (B+16)'(h);
      w = (w << DOWN_SHIFT) >> UP_SHIFT;
      return w[15:0];
   endfunction

   logic [B-1:0]   acc_ff, acc_in;
   logic [B-1:0]   step_ff, step_in;
   logic [7:0]     sat_ff, val_ff, alpha_ff;
   logic [2:0]     sector_ff;
   logic [B-1:0]   frac_ff;
   logic [B+7:0]   sf_ff;
   logic [B+15:0]  prod_ff;
   logic [16:0]    x_ff;
   logic [7:0]     q0_ff;
   logic [7:0]     chan_p_ff, chan_q_ff, chan_t_ff;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [31:0]    color_ff;
   logic [15:0]    hue_ff;

   logic [B+2:0]   hue6;
   logic [B+7:0]   x_p, x_q, x_t;
   logic [7:0]     mul_a;
   logic [B+7:0]   mul_b;
   logic [B+15:0]  mul_out;
   logic [B+16:0]  biased;
   logic [24:0]    x257;
   logic [15:0]    q0_255;
   logic [16:0]    rem;
   logic [7:0]     quot;
   logic [7:0]     red, green, blue;

   assign hue6 = (B+3)'({acc_ff, 1'b0}) + (B+3)'({acc_ff, 2'b0});

   // channel numerators over 255 * 2^B
   assign x_p = {8'd255 - sat_ff, {B{1'b0}}};
   assign x_q = FULL_SCALE - sf_ff;
   assign x_t = x_p + sf_ff;

   always_comb begin
      if (cmd.op == grhsv_pkg::OP_MUL_SF) begin
         mul_a = sat_ff;
         mul_b = (B+8)'(frac_ff);
      end else begin
         mul_a = val_ff;
         case (cmd.chan)
            grhsv_pkg::CHAN_P: mul_b = x_p;
            grhsv_pkg::CHAN_Q: mul_b = x_q;
            default:           mul_b = x_t;
         endcase
      end
   end

   assign mul_out = (B+16)'(mul_a) * (B+16)'(mul_b);

   // round to nearest: add half a unit, then drop the hue scale
   assign biased = (B+17)'(prod_ff) + ROUND_BIAS;

   // divide by 255: reciprocal estimate, then one correction step
   assign x257   = (25)'({x_ff, 8'b0}) + (25)'(x_ff);
   assign q0_255 = {q0_ff, 8'b0} - (16)'(q0_ff);
   assign rem    = x_ff - (17)'(q0_255);
   assign quot   = (rem >= 17'd255) ? q0_ff + 8'd1 : q0_ff;

   always_comb begin
      case (sector_ff)
         SEC_RED_YELLOW:   begin red = val_ff;    green = chan_t_ff; blue = chan_p_ff; end
         SEC_YELLOW_GREEN: begin red = chan_q_ff; green = val_ff;    blue = chan_p_ff; end
         SEC_GREEN_CYAN:   begin red = chan_p_ff; green = val_ff;    blue = chan_t_ff; end
         SEC_CYAN_BLUE:    begin red = chan_p_ff; green = chan_q_ff; blue = val_ff;    end
         SEC_BLUE_MAGENTA: begin red = chan_t_ff; green = chan_p_ff; blue = val_ff;    end
         default:          begin red = val_ff;    green = chan_p_ff; blue = chan_q_ff; end
      endcase
   end

   always_comb begin
      acc_in  = acc_ff;
      step_in = step_ff;
      if (cmd.op == grhsv_pkg::OP_ACCEPT) begin
         acc_in = acc_ff + step_ff;
      end
      if (csr_we) begin
         case (csr_index)
            grhsv_pkg::CSR_HUE_SEED: acc_in  = to_hue(csr_wdata);
            grhsv_pkg::CSR_HUE_STEP: step_in = to_hue(csr_wdata);
            default: ;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         step_ff      <= to_hue(grhsv_pkg::HUE_STEP_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         grhsv_pkg::OP_ACCEPT: begin
            sat_ff   <= req_saturation;
            val_ff   <= req_value_level;
            alpha_ff <= req_alpha_level;
         end
         grhsv_pkg::OP_HUE: begin
            sector_ff <= hue6[B+2:B];
            frac_ff   <= hue6[B-1:0];
         end
         grhsv_pkg::OP_MUL_SF: sf_ff   <= mul_out[B+7:0];
         grhsv_pkg::OP_MUL:    prod_ff <= mul_out;
         grhsv_pkg::OP_ROUND:  x_ff    <= biased[B+16:B];
         grhsv_pkg::OP_DIV:    q0_ff   <= x257[23:16];
         grhsv_pkg::OP_FIX: begin
            case (cmd.chan)
               grhsv_pkg::CHAN_P: chan_p_ff <= quot;
               grhsv_pkg::CHAN_Q: chan_q_ff <= quot;
               default:           chan_t_ff <= quot;
            endcase
         end
         default: ;
      endcase
      if (cmd.load_out) begin
         color_ff <= {alpha_ff, blue, green, red};
         hue_ff   <= to_16(acc_ff);
      end
   end

   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_color_abgr  = color_ff;
   assign rsp_hue_used    = hue_ff;

endmodule

`default_nettype wire

### rtl/core/golden_ratio_hsv_color_generator.sv
// ----------------------------------------------------------------------------
// golden_ratio_hsv_color_generator
// Steps a hue accumulator per request and converts HSV to packed ABGR.
// ----------------------------------------------------------------------------
//   channel   direction  handshake      payload
//   req_bus   in         valid/ready    saturation, value_level, alpha_level
//   rsp_bus   out        valid/ready    color_abgr, hue_used
//   csr_*     in         csr_we         csr_index, csr_wdata (hue_seed, hue_step)
//
// After acceptance the sequencer updates the hue, then runs one shared
// multiplier for s*f and for the three channel products, each channel
// product followed by a round and a two-step divide by 255.
// req_ready is high only while the sequencer is idle; a finished colour
// waits in the output register, so the next request is taken meanwhile.
// A stalled response holds the sequencer in its last step until taken.
// Synchronous reset clears the accumulator and loads the default step.
// ----------------------------------------------------------------------------
`default_nettype none

module golden_ratio_hsv_color_generator #(
   parameter int HUE_BITS = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   grhsv_req_if.sink                                 req_bus,
   grhsv_rsp_if.source                               rsp_bus,
   input  wire logic                                 csr_we,
   input  wire logic [grhsv_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [grhsv_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   grhsv_pkg::cmd_type    cmd;
   grhsv_pkg::status_type status;
   logic                  req_ready;
   logic                  rsp_valid;
   logic [31:0]           rsp_color_abgr;
   logic [15:0]           rsp_hue_used;

   grhsv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   grhsv_datapath #(
      .HUE_BITS (HUE_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_saturation  (req_bus.saturation),
      .req_value_level (req_bus.value_level),
      .req_alpha_level (req_bus.alpha_level),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_bus.ready),
      .rsp_color_abgr  (rsp_color_abgr),
      .rsp_hue_used    (rsp_hue_used)
   );

   assign req_bus.ready      = req_ready;
   assign rsp_bus.valid      = rsp_valid;
   assign rsp_bus.color_abgr = rsp_color_abgr;
   assign rsp_bus.hue_used   = rsp_hue_used;

endmodule

`default_nettype wire

### rtl/core/grhsv_checker.sv
// ----------------------------------------------------------------------------
// grhsv_checker
// Port-level checks on the colour generator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "golden_ratio_hsv_color_generator_macros.svh"

module grhsv_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] rsp_color_abgr,
   input wire logic [15:0] rsp_hue_used
);

   // a stalled colour keeps its payload
   `GRHSV_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_color_abgr) && $stable(rsp_hue_used),
      "stalled response changed")

   // one request at a time: the sequencer leaves idle on acceptance
   `GRHSV_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready,
      !req_ready, "request taken while busy")

   // a new colour only appears at the end of a request's sequence
   `GRHSV_ASSERT_SAME(a_rsp_from_seq, clock, reset, $rose(rsp_valid),
      !$past(req_ready), "response raised without a finished request")

   // reset drops any pending response
   `GRHSV_ASSERT_NEXT(a_reset_clears, clock, 1'b0, reset,
      !rsp_valid, "response valid after reset")

endmodule

bind golden_ratio_hsv_color_generator grhsv_checker u_grhsv_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_bus.valid),
   .req_ready      (req_bus.ready),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_color_abgr (rsp_bus.color_abgr),
   .rsp_hue_used   (rsp_bus.hue_used)
);

`default_nettype wire

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: golden-ratio HSV colour generator bench
// Drives colour requests with random gaps and response stalls, predicts each
// colour from its own hue accumulator and HSV conversion, and checks the
// colours in order. Register settings change between phases while idle.
// ----------------------------------------------------------------------------

module tb_top;

   localparam int HUE_BITS     = 16;
   localparam int UP_SHIFT     = (HUE_BITS >= 16) ? HUE_BITS - 16 : 0;
   localparam int DOWN_SHIFT   = (HUE_BITS < 16) ? 16 - HUE_BITS : 0;
   localparam int SETTLE_CYCLES = 40;
   localparam int HOLD_CYCLES  = 400;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int PHASES       = 10;
   localparam int PHASE_ITEMS  = 200;

   // indexes with no register behind them
   localparam logic [grhsv_pkg::CSR_INDEX_BITS-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [grhsv_pkg::CSR_INDEX_BITS-1:0] CSR_SPARE_B = 2'd3;

   typedef struct {
      logic [7:0] saturation;
      logic [7:0] value_level;
      logic [7:0] alpha_level;
   } request_type;

   typedef struct {
      logic [31:0] color_abgr;
      logic [15:0] hue_used;
   } colour_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [grhsv_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [grhsv_pkg::CSR_DATA_BITS-1:0]  csr_wdata;

   grhsv_req_if req_bus ();
   grhsv_rsp_if rsp_bus ();

   golden_ratio_hsv_color_generator #(
      .HUE_BITS(HUE_BITS)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .rsp_bus  (rsp_bus),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   request_type requests_waiting[$];
   colour_type  colours_due[$];
   request_type req_held;

   longint unsigned hue_acc;
   logic [15:0]     hue_step_reg;

   int unsigned req_gap;
   int unsigned rsp_stall;
   int unsigned hold_left;
   int unsigned cycle_count = 0;
   int unsigned fail_count = 0;
   bit          no_idle;
   logic        hold_start;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint unsigned widen_hue(input logic [15:0] x);
      longint unsigned w;
      w = x;
      return ((w << UP_SHIFT) >> DOWN_SHIFT) & ((64'd1 << HUE_BITS) - 1);
   endfunction

   function automatic longint unsigned narrow_hue(input longint unsigned h);
      return ((h << DOWN_SHIFT) >> UP_SHIFT) & 64'hFFFF;
   endfunction

   function automatic longint unsigned round_div(input longint unsigned num,
                                                 input longint unsigned den);
      return (2 * num + den) / (2 * den);
   endfunction

   // advance the hue, then convert HSV to packed ABGR
   function automatic colour_type predict_colour(input request_type rq);
      longint unsigned one, den, h6, sector, f, s, v, pv, qv, tv;
      logic [7:0] r, g, b;
      colour_type c;
      one = 64'd1 << HUE_BITS;
      den = 255 * one;
      s = rq.saturation;
      v = rq.value_level;
      hue_acc = (hue_acc + widen_hue(hue_step_reg)) & (one - 1);
      h6 = hue_acc * 6;
      sector = h6 >> HUE_BITS;
      f = h6 & (one - 1);
      pv = round_div(v * (255 - s), 255);
      qv = round_div(v * (den - s * f), den);
      tv = round_div(v * (den - s * (one - f)), den);
      case (sector)
         0: begin r = 8'(v);  g = 8'(tv); b = 8'(pv); end
         1: begin r = 8'(qv); g = 8'(v);  b = 8'(pv); end
         2: begin r = 8'(pv); g = 8'(v);  b = 8'(tv); end
         3: begin r = 8'(pv); g = 8'(qv); b = 8'(v);  end
         4: begin r = 8'(tv); g = 8'(pv); b = 8'(v);  end
         default: begin r = 8'(v); g = 8'(pv); b = 8'(qv); end
      endcase
      c.color_abgr = {rq.alpha_level, b, g, r};
      c.hue_used = 16'(narrow_hue(hue_acc));
      return c;
   endfunction

   task automatic flag_mismatch(input string what, input longint unsigned got,
                                input longint unsigned want);
      $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin : drive_requests
      request_type nxt;
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            colours_due.push_back(predict_colour(req_held));
            req_gap = no_idle ? 0 : $urandom_range(0, 13);
         end
         // hold an offered request until it is taken
         if (!req_bus.valid || req_bus.ready) begin
            if (req_gap != 0) begin
               req_gap--;
               req_bus.valid <= 1'b0;
            end else if (requests_waiting.size() != 0) begin
               nxt = requests_waiting.pop_front();
               req_held = nxt;
               req_bus.saturation  <= nxt.saturation;
               req_bus.value_level <= nxt.value_level;
               req_bus.alpha_level <= nxt.alpha_level;
               req_bus.valid <= 1'b1;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : check_colours
      colour_type due;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (colours_due.size() == 0) begin
               flag_mismatch("unexpected colour", rsp_bus.color_abgr, 0);
            end else begin
               due = colours_due.pop_front();
               if (rsp_bus.color_abgr !== due.color_abgr)
                  flag_mismatch("color_abgr", rsp_bus.color_abgr, due.color_abgr);
               if (rsp_bus.hue_used !== due.hue_used)
                  flag_mismatch("hue_used", rsp_bus.hue_used, due.hue_used);
            end
            rsp_stall = no_idle ? 0 : $urandom_range(0, 13);
         end else if (rsp_stall != 0) begin
            rsp_stall--;
         end
         rsp_bus.ready <= (rsp_stall == 0) && (hold_left == 0);
      end
   end

   // long receiver hold-off so the block backs up and stalls its input
   always @(posedge clock) begin
      if (reset)
         hold_left <= 0;
      else if (hold_start)
         hold_left <= HOLD_CYCLES;
      else if (hold_left != 0)
         hold_left <= hold_left - 1;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("tb_top NOT OK");
         $finish;
      end
   end

   task automatic add_request(input logic [7:0] s, input logic [7:0] v,
                              input logic [7:0] a);
      request_type rq;
      rq.saturation = s;
      rq.value_level = v;
      rq.alpha_level = a;
      requests_waiting.push_back(rq);
   endtask

   function automatic logic [7:0] pick_level();
      case ($urandom_range(0, 9))
         0: return 8'd0;
         1: return 8'd255;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic write_reg(input logic [grhsv_pkg::CSR_INDEX_BITS-1:0] idx,
                            input logic [grhsv_pkg::CSR_DATA_BITS-1:0] data);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == grhsv_pkg::CSR_HUE_SEED)
         hue_acc = widen_hue(data);
      else if (idx == grhsv_pkg::CSR_HUE_STEP)
         hue_step_reg = data;
   endtask

   task automatic finish_phase();
      while (requests_waiting.size() != 0 || req_bus.valid || colours_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      int i;
      int phase;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = grhsv_pkg::CSR_HUE_SEED;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.saturation = '0;
      req_bus.value_level = '0;
      req_bus.alpha_level = '0;
      rsp_bus.ready = 1'b0;
      hold_start = 1'b0;
      no_idle = 1'b0;
      hue_acc = 0;
      hue_step_reg = grhsv_pkg::HUE_STEP_RESET;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset settings: field extremes and grey
      add_request(8'd0, 8'd0, 8'd0);
      add_request(8'd255, 8'd255, 8'd255);
      add_request(8'd0, 8'd255, 8'd128);
      add_request(8'd0, 8'd77, 8'd1);
      add_request(8'd255, 8'd0, 8'd255);
      add_request(8'd1, 8'd1, 8'd254);
      add_request(8'd254, 8'd255, 8'd0);
      finish_phase();

      // walk through every sector, at full saturation but for every fourth request
      write_reg(grhsv_pkg::CSR_HUE_SEED, 16'd0);
      write_reg(grhsv_pkg::CSR_HUE_STEP, 16'd5461);
      for (i = 0; i < 12; i++)
         add_request((i % 4 == 3) ? 8'd200 : 8'd255, (i % 3 == 2) ? 8'd100 : 8'd255,
                     8'(i * 21));
      finish_phase();

      // zero step, top seed, spare indexes ignored
      write_reg(grhsv_pkg::CSR_HUE_STEP, 16'd0);
      write_reg(CSR_SPARE_A, 16'hFFFF);
      write_reg(CSR_SPARE_B, 16'h5A5A);
      write_reg(grhsv_pkg::CSR_HUE_SEED, 16'hFFFF);
      add_request(8'd255, 8'd255, 8'd255);
      add_request(8'd128, 8'd200, 8'd17);
      add_request(8'd0, 8'd255, 8'd0);
      finish_phase();

      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin
               write_reg(grhsv_pkg::CSR_HUE_SEED, 16'hFFFF);
               write_reg(grhsv_pkg::CSR_HUE_STEP, 16'hFFFF);
            end
            1: begin
               write_reg(grhsv_pkg::CSR_HUE_SEED, 16'd0);
               write_reg(grhsv_pkg::CSR_HUE_STEP, 16'd1);
            end
            2: begin
               write_reg(grhsv_pkg::CSR_HUE_STEP, grhsv_pkg::HUE_STEP_RESET);
               write_reg(grhsv_pkg::CSR_HUE_SEED, 16'($urandom_range(0, 65535)));
            end
            default: begin
               write_reg(grhsv_pkg::CSR_HUE_SEED, 16'($urandom_range(0, 65535)));
               write_reg(grhsv_pkg::CSR_HUE_STEP, 16'($urandom_range(0, 65535)));
               if ($urandom_range(0, 2) == 0)
                  write_reg($urandom_range(0, 1) ? CSR_SPARE_A : CSR_SPARE_B,
                            16'($urandom_range(0, 65535)));
            end
         endcase
         no_idle = (phase % 3 == 1);
         for (i = 0; i < PHASE_ITEMS; i++)
            add_request(pick_level(), pick_level(), 8'($urandom_range(0, 255)));
         if (phase == 4) begin
            @(posedge clock);
            hold_start <= 1'b1;
            @(posedge clock);
            hold_start <= 1'b0;
         end
         finish_phase();
      end

      if (fail_count == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/grhsv_pkg.sv
rtl/core/grhsv_if.sv
rtl/core/grhsv_ctrl.sv
rtl/core/grhsv_datapath.sv
rtl/core/golden_ratio_hsv_color_generator.sv
rtl/core/grhsv_checker.sv
bench/tb_top.sv
